// ===== rtl/lcdnib_pkg.sv =====
// Shared types and constants for the character LCD nibble interface.
// Holds the request/strobe payload structs, command codes and the init table.
// No dependencies.
package lcdnib_pkg;

	typedef struct packed {
		logic [2:0] command;
		logic [7:0] byte_value;
		logic [5:0] column;
		logic [2:0] row;
	} req_t;

	typedef struct packed {
		logic        register_select;
		logic [3:0]  nibble;
		logic [12:0] wait_before_us;
		logic [10:0] wait_after_us;
		logic        last;
	} strobe_t;

	typedef struct packed {
		logic [3:0]  nibble;
		logic [12:0] wait_us;
	} init_entry_t;

	localparam logic [2:0] CMD_INIT   = 3'd0;
	localparam logic [2:0] CMD_WRITE  = 3'd1;
	localparam logic [2:0] CMD_GOTO   = 3'd2;
	localparam logic [2:0] CMD_CLEAR  = 3'd3;
	localparam logic [2:0] CMD_GLYPH  = 3'd4;
	localparam logic [2:0] CMD_SET_RS = 3'd5;

	localparam logic [7:0] BYTE_SET_DDRAM = 8'h80;
	localparam logic [7:0] BYTE_CLEAR     = 8'h01;
	localparam logic [7:0] BYTE_SET_CGRAM = 8'h40;

	localparam logic [7:0] ROW1_BASE = 8'h40;
	localparam logic [7:0] ROW2_BASE = 8'h14;
	localparam logic [7:0] ROW3_BASE = 8'h54;

	localparam logic [12:0] WAIT_BYTE_US  = 13'd40;
	localparam logic [10:0] HOLD_INIT_US  = 11'd40;
	localparam logic [10:0] HOLD_CLEAR_US = 11'd2000;

	localparam logic [3:0] INIT_LAST_STEP = 4'd9;
	localparam logic [3:0] BYTE_LAST_STEP = 4'd1;

	// Power-up nibble run: wake-up nibbles, then 0x28, 0x0C, 0x10.
	function automatic init_entry_t init_step(input logic [3:0] step);
		init_entry_t e;
		unique case (step)
			4'd0:    e = '{nibble: 4'h3, wait_us: 13'd0};
			4'd1:    e = '{nibble: 4'h3, wait_us: 13'd5000};
			4'd2:    e = '{nibble: 4'h3, wait_us: 13'd5000};
			4'd3:    e = '{nibble: 4'h2, wait_us: 13'd100};
			4'd4:    e = '{nibble: 4'h2, wait_us: 13'd80};
			4'd5:    e = '{nibble: 4'h8, wait_us: 13'd0};
			4'd6:    e = '{nibble: 4'h0, wait_us: 13'd80};
			4'd7:    e = '{nibble: 4'hC, wait_us: 13'd0};
			4'd8:    e = '{nibble: 4'h1, wait_us: 13'd80};
			4'd9:    e = '{nibble: 4'h0, wait_us: 13'd0};
			default: e = '{nibble: 4'h0, wait_us: 13'd0};
		endcase
		return e;
	endfunction

endpackage

// ===== rtl/char_lcd_nibble_interface_core.sv =====
// Character LCD 4-bit interface: turns requests into runs of enable strobes.
// A step sequencer walks one strobe per cycle, unless rsp stalls, into an output register.
// Depends on lcdnib_pkg.
// The request transfer enters the run state, and the first strobe is registered from there.
// Throughput: one strobe per cycle while rsp is not stalled; the step counter walks init
// and byte runs to their last step, and strobe-less commands emit no strobes at all.
// Reset: idle, output empty, register select at instruction (0).
module char_lcd_nibble_interface_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  lcdnib_pkg::req_t   req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output lcdnib_pkg::strobe_t rsp
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t              state_q;
	logic                select_level_q;
	logic                is_init_q;
	logic                rs_q;
	logic [7:0]          byte_q;
	logic [10:0]         hold_q;
	logic [3:0]          step_q;
	logic [3:0]          last_step_q;
	logic                rsp_valid_q;
	lcdnib_pkg::strobe_t rsp_q;

	logic                accept;
	logic                advance;
	logic                at_last;
	logic [7:0]          row_base;
	logic [7:0]          goto_byte;
	logic                emits;
	logic [7:0]          load_byte;
	logic [10:0]         load_hold;
	lcdnib_pkg::init_entry_t init_e;
	lcdnib_pkg::strobe_t next_strobe;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign advance   = (state_q == ST_RUN) && (!rsp_valid_q || !rsp_stall);
	assign at_last   = (step_q == last_step_q);

	always_comb begin
		unique case (req.row[1:0])
			2'd1:    row_base = lcdnib_pkg::ROW1_BASE;
			2'd2:    row_base = lcdnib_pkg::ROW2_BASE;
			2'd3:    row_base = lcdnib_pkg::ROW3_BASE;
			default: row_base = 8'h00;
		endcase
	end

	assign goto_byte = lcdnib_pkg::BYTE_SET_DDRAM + row_base + {2'b00, req.column};

	always_comb begin
		emits     = 1'b0;
		load_byte = req.byte_value;
		load_hold = 11'd0;
		case (req.command)
			lcdnib_pkg::CMD_INIT: begin
				emits     = 1'b1;
				load_hold = lcdnib_pkg::HOLD_INIT_US;
			end
			lcdnib_pkg::CMD_WRITE: begin
				emits = 1'b1;
			end
			lcdnib_pkg::CMD_GOTO: begin
				emits     = !req.row[2];
				load_byte = goto_byte;
			end
			lcdnib_pkg::CMD_CLEAR: begin
				emits     = 1'b1;
				load_byte = lcdnib_pkg::BYTE_CLEAR;
				load_hold = lcdnib_pkg::HOLD_CLEAR_US;
			end
			lcdnib_pkg::CMD_GLYPH: begin
				emits     = 1'b1;
				load_byte = lcdnib_pkg::BYTE_SET_CGRAM;
			end
			default: begin
				emits = 1'b0;
			end
		endcase
	end

	assign init_e = lcdnib_pkg::init_step(step_q);

	always_comb begin
		next_strobe.register_select = rs_q;
		if (is_init_q) begin
			next_strobe.nibble         = init_e.nibble;
			next_strobe.wait_before_us = init_e.wait_us;
		end else if (step_q[0] == 1'b0) begin
			next_strobe.nibble         = byte_q[7:4];
			next_strobe.wait_before_us = lcdnib_pkg::WAIT_BYTE_US;
		end else begin
			next_strobe.nibble         = byte_q[3:0];
			next_strobe.wait_before_us = 13'd0;
		end
		next_strobe.wait_after_us = at_last ? hold_q : 11'd0;
		next_strobe.last          = at_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			select_level_q <= 1'b0;
			step_q         <= 4'd0;
			rsp_valid_q    <= 1'b0;
		end else begin
			if (accept) begin
				step_q <= 4'd0;
				if (emits) begin
					state_q <= ST_RUN;
				end
				case (req.command) inside
					lcdnib_pkg::CMD_INIT, lcdnib_pkg::CMD_GOTO,
					lcdnib_pkg::CMD_CLEAR, lcdnib_pkg::CMD_GLYPH: begin
						select_level_q <= 1'b1;
					end
					lcdnib_pkg::CMD_SET_RS: begin
						select_level_q <= req.byte_value[0];
					end
					default: begin
						select_level_q <= select_level_q;
					end
				endcase
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
				step_q      <= step_q + 4'd1;
				if (at_last) begin
					state_q <= ST_IDLE;
				end
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: load on transfer or strobe advance, no reset needed.
	always_ff @(posedge clk) begin
		if (accept) begin
			is_init_q   <= (req.command == lcdnib_pkg::CMD_INIT);
			rs_q        <= (req.command == lcdnib_pkg::CMD_WRITE) ? select_level_q : 1'b0;
			byte_q      <= load_byte;
			hold_q      <= load_hold;
			last_step_q <= (req.command == lcdnib_pkg::CMD_INIT) ?
				lcdnib_pkg::INIT_LAST_STEP : lcdnib_pkg::BYTE_LAST_STEP;
		end
		if (advance) begin
			rsp_q <= next_strobe;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== rtl/lcdnib_checker.sv =====
// Port-level checks for the character LCD nibble interface.
// Depends on lcdnib_pkg; bound to char_lcd_nibble_interface_core.
module lcdnib_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_stall,
	input lcdnib_pkg::req_t    req,
	input logic                rsp_valid,
	input logic                rsp_stall,
	input lcdnib_pkg::strobe_t rsp
);

	// Hold a stalled strobe.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled strobe changed");

	// A byte write always starts a run, so the request side goes busy.
	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req.command == lcdnib_pkg::CMD_WRITE |=> req_stall)
		else $error("write request did not start a run");

	// Hold time shows only on the final strobe.
	a_hold_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.last |-> rsp.wait_after_us == 11'd0)
		else $error("hold time on a non-final strobe");

	// No new request while a run is still unfinished.
	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.last |-> req_stall)
		else $error("request taken in the middle of a run");

endmodule

bind char_lcd_nibble_interface_core lcdnib_checker u_lcdnib_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
